// File: rtl/eulerian_cycle_finder_macros.svh
// Assertion helpers used by the RTL.
`ifndef EULERIAN_CYCLE_FINDER_MACROS_SVH
`define EULERIAN_CYCLE_FINDER_MACROS_SVH

// Implication checked at every edge outside reset.
`define ECF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ecf check failed");

// Implication whose consequent is checked in the next cycle.
`define ECF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ecf check failed");

`endif

// File: rtl/ecf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ecf_pkg;
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_FINISH = 2'd2,
        OP_READ   = 2'd3
    } t_opcode;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_VERTEX = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    localparam logic [1:0] ST_NOT_EULER = 2'd0;
    localparam logic [1:0] ST_EULER     = 2'd1;
    localparam logic [1:0] ST_ERROR     = 2'd2;
endpackage
`default_nettype wire

// File: rtl/ecf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ecf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/eulerian_cycle_finder.sv
`timescale 1ns / 1ps
`default_nettype none
// Eulerian cycle finder for a directed graph.
// Input: pulse i_start with i_opcode/i_tail_vertex/i_head_vertex while o_busy
// is low. Opcodes: clear, add edge, finish, read next cycle vertex.
// Finish and read produce one result, shown for one cycle with o_valid;
// the receiver cannot stall, so results are never held.
// Config: i_cfg_we writes i_cfg_wdata into vertex_count (reset 256).
// Steps: add edge reads the tail row, writes it and fetches the head row, then
// writes the head row (a dropped edge only sets the error flag); read fetches
// the vertex, then shows it, or shows an empty result when nothing is left.
// Clear sweeps the vertex table. Finish runs up to three sweeps of the vertex
// table, two reachability searches (forward and backward) and the walk.
// Reset: a clearing pass over the vertex table runs after reset with
// o_busy high; configuration writes are taken throughout.
module eulerian_cycle_finder #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    output logic            o_busy,
    input  wire logic [1:0] i_opcode,
    input  wire logic [7:0] i_tail_vertex,
    input  wire logic [7:0] i_head_vertex,
    input  wire logic       i_cfg_we,
    input  wire logic [8:0] i_cfg_wdata,
    output logic            o_valid,
    output logic [1:0]      o_kind,
    output logic [1:0]      o_status,
    output logic [7:0]      o_vertex,
    output logic            o_last
);
`include "eulerian_cycle_finder_macros.svh"
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = $clog2(MAX_EDGES + 1);
    localparam int EA = $clog2(MAX_EDGES);
    localparam int TW = $clog2(MAX_EDGES + 2);
    localparam logic [EW-1:0] NIL = EW'(MAX_EDGES);

    typedef enum logic [15:0] {
        S_CLR     = 16'h0001,
        S_IDLE    = 16'h0002,
        S_ADD     = 16'h0004,
        S_RD      = 16'h0008,
        S_SCAN    = 16'h0010,
        S_SCAN_W  = 16'h0020,
        S_DFS     = 16'h0040,
        S_DFS_E   = 16'h0080,
        S_DFS_W   = 16'h0100,
        S_CHK     = 16'h0200,
        S_CHK_W   = 16'h0400,
        S_WLK     = 16'h0800,
        S_WLK_E   = 16'h1000,
        S_WLK_P   = 16'h2000,
        S_DONE    = 16'h4000,
        S_ADD_W   = 16'h8000
    } t_state;

    t_state r_state, n_state;
    logic [8:0]    r_vcount;
    logic [EW-1:0] r_etotal;
    logic          r_err;
    logic [TW-1:0] r_tlen, r_rcur;
    logic [VW:0]   r_cnt;
    logic [VW-1:0] r_s;
    logic          r_has_s, r_fwd, r_bad;
    logic [1:0]    r_pass;
    logic [VW:0]   r_sp;
    logic [TW-1:0] r_wsp, r_n;
    logic [VW-1:0] r_u, r_t, r_h;
    logic [EW-1:0] r_e;

    // vertex table: {out_head, in_head, out_deg, in_deg}, visit marks, cursor
    localparam int VTW = 4 * EW;
    logic          vt_we;   logic [VW-1:0] vt_wa, vt_ra; logic [VTW-1:0] vt_wd, vt_rd;
    logic          vm_we;   logic [VW-1:0] vm_wa, vm_ra; logic vm_wd, vm_rd;
    logic          wc_we;   logic [VW-1:0] wc_wa, wc_ra; logic [EW-1:0] wc_wd, wc_rd;
    // edge table: {out_next, in_next, target, source}
    localparam int ETW = 2 * EW + 2 * VW;
    logic          et_we;   logic [EA-1:0] et_wa, et_ra; logic [ETW-1:0] et_wd, et_rd;
    logic          ss_we;   logic [VW-1:0] ss_wa, ss_ra;
    logic [VW+EW-1:0] ss_wd, ss_rd;
    logic          ts_we;   logic [TW-1:0] ts_wa, ts_ra; logic [VW-1:0] ts_wd, ts_rd;
    logic          to_we;   logic [TW-1:0] to_wa, to_ra; logic [VW-1:0] to_wd, to_rd;
    // bypass a frame written to the address read in the same cycle
    logic             r_ss_byp;
    logic [VW+EW-1:0] r_ss_wd;

    ecf_ram #(.WIDTH(VTW), .DEPTH(MAX_VERTICES)) u_vt (.i_clk, .i_we(vt_we),
        .i_waddr(vt_wa), .i_wdata(vt_wd), .i_raddr(vt_ra), .o_rdata(vt_rd));
    ecf_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_vm (.i_clk, .i_we(vm_we),
        .i_waddr(vm_wa), .i_wdata(vm_wd), .i_raddr(vm_ra), .o_rdata(vm_rd));
    ecf_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_wc (.i_clk, .i_we(wc_we),
        .i_waddr(wc_wa), .i_wdata(wc_wd), .i_raddr(wc_ra), .o_rdata(wc_rd));
    ecf_ram #(.WIDTH(ETW), .DEPTH(MAX_EDGES)) u_et (.i_clk, .i_we(et_we),
        .i_waddr(et_wa), .i_wdata(et_wd), .i_raddr(et_ra), .o_rdata(et_rd));
    ecf_ram #(.WIDTH(VW + EW), .DEPTH(MAX_VERTICES)) u_ss (.i_clk, .i_we(ss_we),
        .i_waddr(ss_wa), .i_wdata(ss_wd), .i_raddr(ss_ra), .o_rdata(ss_rd));
    ecf_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES + 1)) u_ts (.i_clk, .i_we(ts_we),
        .i_waddr(ts_wa), .i_wdata(ts_wd), .i_raddr(ts_ra), .o_rdata(ts_rd));
    ecf_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES + 1)) u_to (.i_clk, .i_we(to_we),
        .i_waddr(to_wa), .i_wdata(to_wd), .i_raddr(to_ra), .o_rdata(to_rd));

    wire [EW-1:0] vt_oh = vt_rd[4*EW-1:3*EW];
    wire [EW-1:0] vt_ih = vt_rd[3*EW-1:2*EW];
    wire [EW-1:0] vt_od = vt_rd[2*EW-1:EW];
    wire [EW-1:0] vt_id = vt_rd[EW-1:0];
    wire [EW-1:0] et_on = et_rd[ETW-1:ETW-EW];
    wire [EW-1:0] et_in = et_rd[ETW-EW-1:2*VW];
    wire [VW-1:0] et_tg = et_rd[2*VW-1:VW];
    wire [VW-1:0] et_sr = et_rd[VW-1:0];
    wire [VW+EW-1:0] ss_q = r_ss_byp ? r_ss_wd : ss_rd;
    wire [EW-1:0] ss_cur = ss_q[EW-1:0];
    wire [VW-1:0] ss_vtx = ss_q[VW+EW-1:EW];

    // effective vertex count, VW+1 bits wide
    logic [VW:0] vc;
    always_comb begin
        if ({23'd0, r_vcount} > 32'(MAX_VERTICES)) vc = (VW+1)'(MAX_VERTICES);
        else vc = (VW+1)'(r_vcount);
    end

    logic          n_valid;
    logic [1:0]    n_kind, n_status;
    logic [7:0]    n_vertex;
    logic          n_last;
    logic [8:0]    n_vcount;
    logic [EW-1:0] n_etotal, n_e;
    logic          n_err, n_has_s, n_fwd, n_bad;
    logic [TW-1:0] n_tlen, n_rcur, n_wsp, n_n;
    logic [VW:0]   n_cnt, n_sp;
    logic [VW-1:0] n_s, n_u, n_t, n_h;
    logic [1:0]    n_pass;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state; n_vcount = i_cfg_we ? i_cfg_wdata : r_vcount;
        n_etotal = r_etotal; n_err = r_err; n_tlen = r_tlen; n_rcur = r_rcur;
        n_cnt = r_cnt; n_s = r_s; n_has_s = r_has_s; n_fwd = r_fwd; n_bad = r_bad;
        n_pass = r_pass; n_sp = r_sp; n_wsp = r_wsp; n_n = r_n; n_u = r_u;
        n_t = r_t; n_h = r_h; n_e = r_e;
        n_valid = 1'b0; n_kind = ecf_pkg::KIND_STATUS; n_status = ecf_pkg::ST_NOT_EULER;
        n_vertex = '0; n_last = 1'b0;
        vt_we = 1'b0; vt_wa = '0; vt_wd = '0; vt_ra = '0;
        vm_we = 1'b0; vm_wa = '0; vm_wd = 1'b0; vm_ra = '0;
        wc_we = 1'b0; wc_wa = '0; wc_wd = '0; wc_ra = '0;
        et_we = 1'b0; et_wa = '0; et_wd = '0; et_ra = '0;
        ss_we = 1'b0; ss_wa = '0; ss_wd = '0; ss_ra = '0;
        ts_we = 1'b0; ts_wa = '0; ts_wd = '0; ts_ra = '0;
        to_we = 1'b0; to_wa = '0; to_wd = '0; to_ra = '0;
        case (r_state)
            S_CLR: begin
                vt_we = 1'b1; vt_wa = r_cnt[VW-1:0]; vt_wd = {NIL, NIL, EW'(0), EW'(0)};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (VW+1)'(MAX_VERTICES - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_t = i_tail_vertex[VW-1:0]; n_h = i_head_vertex[VW-1:0];
                    case (ecf_pkg::t_opcode'(i_opcode))
                        ecf_pkg::OP_CLEAR: begin
                            n_etotal = '0; n_err = 1'b0; n_tlen = '0; n_rcur = '0;
                            n_cnt = '0; n_state = S_CLR;
                        end
                        ecf_pkg::OP_ADD: begin
                            n_tlen = '0; n_rcur = '0;
                            if ({1'b0, i_tail_vertex} >= 9'(vc) ||
                                {1'b0, i_head_vertex} >= 9'(vc) || r_etotal >= NIL) begin
                                n_err = 1'b1;
                            end else begin
                                vt_ra = i_tail_vertex[VW-1:0];
                                n_state = S_ADD;
                            end
                        end
                        ecf_pkg::OP_FINISH: begin
                            n_tlen = '0; n_rcur = '0;
                            if (r_err) begin
                                n_valid = 1'b1; n_status = ecf_pkg::ST_ERROR;
                            end else begin
                                n_cnt = '0; n_has_s = 1'b0; n_bad = 1'b0; n_pass = 2'd0;
                                vt_ra = '0; n_state = S_SCAN;
                            end
                        end
                        ecf_pkg::OP_READ: begin
                            if (r_rcur < r_tlen) begin
                                to_ra = r_tlen - r_rcur; n_state = S_RD;
                            end else begin
                                n_valid = 1'b1; n_kind = ecf_pkg::KIND_EMPTY;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                // tail row is valid now; write it, then fetch head row
                vt_we = 1'b1; vt_wa = r_t;
                vt_wd = {r_etotal, vt_ih, vt_od + 1'b1, vt_id};
                et_we = 1'b1; et_wa = r_etotal[EA-1:0];
                et_wd = {vt_oh, NIL, r_h, r_t};
                n_e = vt_oh;
                vt_ra = r_h;
                n_state = S_ADD_W;
            end
            S_ADD_W: begin
                // forward the tail write when head equals tail
                vt_we = 1'b1; vt_wa = r_h;
                if (r_h == r_t) begin
                    vt_wd = {vt_oh, r_etotal, vt_od, vt_id + 1'b1};
                    et_wd = {vt_oh, vt_ih, r_h, r_t};
                    vt_wd[4*EW-1:3*EW] = r_etotal;
                    vt_wd[2*EW-1:EW] = vt_od + 1'b1;
                    et_wd[ETW-1:ETW-EW] = r_e;
                end else begin
                    vt_wd = {vt_oh, r_etotal, vt_od, vt_id + 1'b1};
                    et_wd = {r_e, vt_ih, r_h, r_t};
                end
                et_we = 1'b1; et_wa = r_etotal[EA-1:0];
                n_etotal = r_etotal + 1'b1;
                n_state = S_IDLE;
            end
            S_RD: begin
                n_valid = 1'b1; n_kind = ecf_pkg::KIND_VERTEX;
                n_vertex = 8'(to_rd);
                n_last = (r_rcur + 1'b1 == r_tlen);
                n_rcur = r_rcur + 1'b1;
                n_state = S_IDLE;
            end
            // sweep: pass 0 finds start and checks high vertices, clears marks, loads cursors
            S_SCAN: begin
                vt_ra = r_cnt[VW-1:0];
                n_state = S_SCAN_W;
            end
            S_SCAN_W: begin
                vm_we = 1'b1; vm_wa = r_cnt[VW-1:0]; vm_wd = 1'b0;
                wc_we = 1'b1; wc_wa = r_cnt[VW-1:0]; wc_wd = vt_oh;
                if (r_cnt >= vc) begin
                    if (vt_od != '0 || vt_id != '0) n_bad = 1'b1;
                end else if (vt_od != '0 && !r_has_s) begin
                    n_has_s = 1'b1; n_s = r_cnt[VW-1:0];
                end
                n_cnt = r_cnt + 1'b1;
                vt_ra = n_cnt[VW-1:0];
                if (r_cnt == (VW+1)'(MAX_VERTICES - 1)) begin
                    if (n_bad) begin
                        n_valid = 1'b1; n_status = ecf_pkg::ST_ERROR; n_state = S_IDLE;
                    end else if (!n_has_s) begin
                        n_valid = 1'b1; n_status = ecf_pkg::ST_EULER; n_state = S_IDLE;
                    end else begin
                        n_fwd = 1'b1; vt_ra = n_s; n_state = S_DFS;
                    end
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_DFS: begin
                // push start frame
                vm_we = 1'b1; vm_wa = r_s; vm_wd = 1'b1;
                ss_we = 1'b1; ss_wa = '0; ss_wd = {r_s, r_fwd ? vt_oh : vt_ih};
                n_sp = (VW+1)'(1); ss_ra = '0; n_state = S_DFS_E;
            end
            S_DFS_E: begin
                // ss_q is top frame
                if (r_sp == '0) begin
                    n_cnt = '0; vt_ra = '0; vm_ra = '0; n_state = S_CHK;
                end else if (ss_cur >= NIL) begin
                    n_sp = r_sp - 1'b1;
                    ss_ra = VW'(r_sp - 2'd2);
                    n_state = S_DFS_W;
                    n_e = NIL;
                end else begin
                    et_ra = ss_cur[EA-1:0]; n_u = ss_vtx; n_e = ss_cur;
                    n_state = S_DFS_W;
                end
            end
            S_DFS_W: begin
                if (r_e == NIL) begin
                    ss_ra = VW'(r_sp - 1'b1);
                    n_state = S_DFS_E;
                end else begin
                    // advance cursor, then read mark of neighbor
                    ss_we = 1'b1; ss_wa = VW'(r_sp - 1'b1);
                    ss_wd = {r_u, r_fwd ? et_on : et_in};
                    n_h = r_fwd ? et_tg : et_sr;
                    vm_ra = n_h; vt_ra = n_h;
                    n_e = NIL; n_pass = 2'd1;
                    n_state = S_WLK_P;
                end
            end
            S_WLK_P: begin
                if (r_pass == 2'd1) begin
                    // DFS neighbor check
                    if (!vm_rd && r_sp < (VW+1)'(MAX_VERTICES)) begin
                        vm_we = 1'b1; vm_wa = r_h; vm_wd = 1'b1;
                        ss_we = 1'b1; ss_wa = r_sp[VW-1:0];
                        ss_wd = {r_h, r_fwd ? vt_oh : vt_ih};
                        n_sp = r_sp + 1'b1;
                        ss_ra = r_sp[VW-1:0];
                    end else begin
                        ss_ra = VW'(r_sp - 1'b1);
                    end
                    n_state = S_DFS_E;
                end else begin
                    // walk: cursor of r_u available in wc_rd
                    if (wc_rd < NIL && r_wsp <= TW'(MAX_EDGES)) begin
                        et_ra = wc_rd[EA-1:0]; n_state = S_WLK_E;
                    end else begin
                        if (r_n <= TW'(MAX_EDGES)) begin
                            to_we = 1'b1; to_wa = r_n; to_wd = r_u; n_n = r_n + 1'b1;
                        end
                        n_wsp = r_wsp - 1'b1;
                        ts_ra = n_wsp;
                        n_state = S_WLK;
                    end
                end
            end
            S_CHK: begin
                vt_ra = r_cnt[VW-1:0]; vm_ra = r_cnt[VW-1:0];
                n_state = S_CHK_W;
            end
            S_CHK_W: begin
                if (r_cnt < vc) begin
                    if (vt_od != '0 && !vm_rd) n_bad = 1'b1;
                    if (!r_fwd && vt_od != vt_id) n_bad = 1'b1;
                end
                vm_we = 1'b1; vm_wa = r_cnt[VW-1:0]; vm_wd = 1'b0;
                n_cnt = r_cnt + 1'b1;
                vt_ra = n_cnt[VW-1:0]; vm_ra = n_cnt[VW-1:0];
                n_state = S_CHK;
                if (r_cnt == (VW+1)'(MAX_VERTICES - 1)) begin
                    if (n_bad) begin
                        n_valid = 1'b1; n_status = ecf_pkg::ST_NOT_EULER; n_state = S_IDLE;
                    end else if (r_fwd) begin
                        n_fwd = 1'b0; vt_ra = r_s; n_state = S_DFS;
                    end else begin
                        ts_we = 1'b1; ts_wa = '0; ts_wd = r_s;
                        n_wsp = TW'(1); n_n = '0; n_u = r_s; n_pass = 2'd2;
                        wc_ra = r_s; n_state = S_WLK_P;
                    end
                end
            end
            S_WLK_E: begin
                wc_we = 1'b1; wc_wa = r_u; wc_wd = et_on;
                ts_we = 1'b1; ts_wa = r_wsp; ts_wd = r_u;
                n_wsp = r_wsp + 1'b1;
                n_u = et_tg; wc_ra = et_tg;
                n_state = S_DONE;
            end
            S_DONE: begin
                // cursor write to the same vertex lands this cycle; re-read
                wc_ra = r_u; n_state = S_WLK_P;
            end
            S_WLK: begin
                n_u = ts_rd; wc_ra = ts_rd;
                if (r_wsp == '0) begin
                    n_tlen = (r_n != '0) ? r_n - 1'b1 : '0;
                    n_valid = 1'b1; n_status = ecf_pkg::ST_EULER; n_state = S_IDLE;
                end else begin
                    n_state = S_DONE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_vcount <= 9'd256; r_etotal <= '0; r_err <= 1'b0;
            r_tlen <= '0; r_rcur <= '0; r_cnt <= '0; o_valid <= 1'b0;
        end else begin
            r_state <= n_state; r_vcount <= n_vcount; r_etotal <= n_etotal;
            r_err <= n_err; r_tlen <= n_tlen; r_rcur <= n_rcur; r_cnt <= n_cnt;
            o_valid <= n_valid;
        end
        r_s <= n_s; r_has_s <= n_has_s; r_fwd <= n_fwd; r_bad <= n_bad;
        r_pass <= n_pass; r_sp <= n_sp; r_wsp <= n_wsp; r_n <= n_n; r_u <= n_u;
        r_t <= n_t; r_h <= n_h; r_e <= n_e;
        r_ss_byp <= ss_we && (ss_wa == ss_ra); r_ss_wd <= ss_wd;
        o_kind <= n_kind; o_status <= n_status; o_vertex <= n_vertex; o_last <= n_last;
    end

    `ECF_ASSERT_IMP(a_read_bound, i_clk, i_rst_n, 1'b1, r_rcur <= r_tlen)
    `ECF_ASSERT_IMP(a_edge_bound, i_clk, i_rst_n, 1'b1, r_etotal <= NIL)
    `ECF_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n,
        i_start && !o_busy && i_opcode == ecf_pkg::OP_FINISH, o_valid || o_busy)
endmodule
`default_nettype wire

// File: dv/eulerian_cycle_finder_test.sv
`timescale 1ns / 1ps

module eulerian_cycle_finder_test;

    typedef struct {
        logic [1:0] kind;
        logic [1:0] status;
        logic [7:0] vertex;
        logic       last;
    } t_euler_result;

    class euler_scoreboard;
        int unsigned vcount;
        int unsigned out_head[256], in_head[256], out_deg[256], in_deg[256];
        int unsigned out_nxt[1024], in_nxt[1024], tgt[1024], src[1024];
        int unsigned tour[1025], walk_stack[1025], cur[256];
        bit          seen[256];
        int unsigned n_edges, tour_len, rd_ptr;
        bit          err_flag;
        t_euler_result pending[$];
        int          mismatches;

        function void reset_state();
            vcount = 256;
            mismatches = 0;
            clear_graph();
        endfunction

        function void clear_graph();
            for (int v = 0; v < 256; v++) begin
                out_head[v] = 1024;
                in_head[v]  = 1024;
                out_deg[v]  = 0;
                in_deg[v]   = 0;
                seen[v]     = 0;
            end
            n_edges = 0;
            err_flag = 0;
            tour_len = 0;
            rd_ptr = 0;
        endfunction

        function int unsigned eff_count();
            return (vcount > 256) ? 256 : vcount;
        endfunction

        function void mark_reachable(int unsigned start, bit fwd);
            int unsigned sc[256];
            int unsigned e, w, sp;
            for (int v = 0; v < 256; v++) seen[v] = 0;
            seen[start] = 1;
            sc[0] = fwd ? out_head[start] : in_head[start];
            sp = 1;
            while (sp > 0) begin
                e = sc[sp - 1];
                if (e >= 1024) begin
                    sp--;
                end else begin
                    sc[sp - 1] = fwd ? out_nxt[e] : in_nxt[e];
                    w = fwd ? tgt[e] : src[e];
                    if (!seen[w] && sp < 256) begin
                        seen[w] = 1;
                        sc[sp] = fwd ? out_head[w] : in_head[w];
                        sp++;
                    end
                end
            end
        endfunction

        function bit all_reached(int unsigned vc);
            for (int v = 0; v < vc; v++)
                if (out_deg[v] > 0 && !seen[v]) return 0;
            return 1;
        endfunction

        function logic [1:0] run_finish();
            int unsigned vc, s, sp, n, u, e;
            vc = eff_count();
            tour_len = 0;
            rd_ptr = 0;
            if (err_flag) return ecf_pkg::ST_ERROR;
            for (int v = vc; v < 256; v++)
                if (out_deg[v] != 0 || in_deg[v] != 0) return ecf_pkg::ST_ERROR;
            for (s = 0; s < vc; s++)
                if (out_deg[s] > 0) break;
            if (s >= vc) return ecf_pkg::ST_EULER;
            mark_reachable(s, 1);
            if (!all_reached(vc)) return ecf_pkg::ST_NOT_EULER;
            mark_reachable(s, 0);
            if (!all_reached(vc)) return ecf_pkg::ST_NOT_EULER;
            for (int v = 0; v < vc; v++)
                if (out_deg[v] != in_deg[v]) return ecf_pkg::ST_NOT_EULER;
            for (int v = 0; v < 256; v++) cur[v] = out_head[v];
            n = 0;
            walk_stack[0] = s;
            sp = 1;
            u = s;
            while (sp > 0) begin
                e = cur[u];
                if (e < 1024 && sp <= 1024) begin
                    cur[u] = out_nxt[e];
                    walk_stack[sp] = u;
                    sp++;
                    u = tgt[e];
                end else begin
                    if (n <= 1024) begin
                        tour[n] = u;
                        n++;
                    end
                    sp--;
                    u = walk_stack[sp];
                end
            end
            tour_len = (n > 0) ? n - 1 : 0;
            return ecf_pkg::ST_EULER;
        endfunction

        function void note_transaction(ecf_pkg::t_opcode op, logic [7:0] t, logic [7:0] h);
            t_euler_result r;
            int unsigned vc, e, idx;
            r = '{kind: ecf_pkg::KIND_STATUS, status: ecf_pkg::ST_NOT_EULER,
                  vertex: 8'd0, last: 1'b0};
            case (op)
                ecf_pkg::OP_CLEAR: clear_graph();
                ecf_pkg::OP_ADD: begin
                    vc = eff_count();
                    tour_len = 0;
                    rd_ptr = 0;
                    if (t >= vc || h >= vc || n_edges >= 1024) begin
                        err_flag = 1;
                    end else begin
                        e = n_edges;
                        tgt[e] = h;
                        out_nxt[e] = out_head[t];
                        out_head[t] = e;
                        src[e] = t;
                        in_nxt[e] = in_head[h];
                        in_head[h] = e;
                        out_deg[t]++;
                        in_deg[h]++;
                        n_edges = e + 1;
                    end
                end
                ecf_pkg::OP_FINISH: begin
                    r.status = run_finish();
                    pending = {pending, r};
                end
                ecf_pkg::OP_READ: begin
                    if (rd_ptr < tour_len) begin
                        idx = tour_len - rd_ptr;
                        r.kind = ecf_pkg::KIND_VERTEX;
                        r.vertex = 8'(tour[idx]);
                        r.last = (rd_ptr + 1 == tour_len);
                        rd_ptr++;
                    end else begin
                        r.kind = ecf_pkg::KIND_EMPTY;
                    end
                    pending = {pending, r};
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_euler_result got);
            t_euler_result want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d status=%0d vertex=%0d last=%0d",
                             got.kind, got.status, got.vertex, got.last);
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind || got.status !== want.status ||
                got.vertex !== want.vertex || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected kind=%0d status=%0d vertex=%0d last=%0d, %s",
                             want.kind, want.status, want.vertex, want.last,
                             $sformatf("got kind=%0d status=%0d vertex=%0d last=%0d",
                                       got.kind, got.status, got.vertex, got.last));
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_start = 1'b0;
    logic [1:0] i_opcode = ecf_pkg::OP_CLEAR;
    logic [7:0] i_tail_vertex = 8'd0;
    logic [7:0] i_head_vertex = 8'd0;
    logic       i_cfg_we = 1'b0;
    logic [8:0] i_cfg_wdata = 9'd0;
    logic       o_busy, o_valid, o_last;
    logic [1:0] o_kind, o_status;
    logic [7:0] o_vertex;

    euler_scoreboard sb;
    int          gap_pct = 0;
    int unsigned sent = 0;

    eulerian_cycle_finder DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_opcode(i_opcode), .i_tail_vertex(i_tail_vertex),
        .i_head_vertex(i_head_vertex), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_valid(o_valid), .o_kind(o_kind), .o_status(o_status),
        .o_vertex(o_vertex), .o_last(o_last)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result('{kind: o_kind, status: o_status, vertex: o_vertex, last: o_last});
    end

    // Called right after a falling edge; returns right after a falling edge.
    task automatic send(ecf_pkg::t_opcode op, logic [7:0] t = 8'd0, logic [7:0] h = 8'd0);
        while ($urandom_range(99) < gap_pct) begin
            i_start = 1'b0;
            @(negedge i_clk);
        end
        i_start = 1'b1;
        i_opcode = op;
        i_tail_vertex = t;
        i_head_vertex = h;
        do @(posedge i_clk); while (o_busy);
        sb.note_transaction(op, t, h);
        sent++;
        @(negedge i_clk);
        i_start = 1'b0;
    endtask

    // Drain every pending result, then let a clear sweep finish.
    task automatic drain();
        i_start = 1'b0;
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_vertex_count(logic [8:0] vc);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_wdata = vc;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.vcount = vc;
    endtask

    function automatic logic [7:0] pick_vertex();
        int unsigned vc;
        vc = sb.eff_count();
        if (vc == 0 || $urandom_range(19) == 0) return 8'($urandom_range(255));
        return 8'($urandom_range(vc - 1));
    endfunction

    task automatic read_tour(int unsigned extra);
        repeat (sb.tour_len + extra) send(ecf_pkg::OP_READ);
    endtask

    task automatic closed_walk();
        logic [7:0] first, prev, nxt;
        int unsigned k;
        k = $urandom_range(1, 12);
        first = pick_vertex();
        prev = first;
        for (int i = 1; i < k; i++) begin
            nxt = pick_vertex();
            send(ecf_pkg::OP_ADD, prev, nxt);
            prev = nxt;
        end
        send(ecf_pkg::OP_ADD, prev, first);
    endtask

    task automatic random_phase(int unsigned quota);
        int unsigned stop_at, r;
        stop_at = sent + quota;
        while (sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 70) begin
                if ($urandom_range(3) != 0) send(ecf_pkg::OP_CLEAR);
                closed_walk();
                if ($urandom_range(2) == 0) closed_walk();
                send(ecf_pkg::OP_FINISH);
                if ($urandom_range(4) == 0) send(ecf_pkg::OP_FINISH);
                read_tour($urandom_range(0, 2));
            end else if (r < 85) begin
                repeat ($urandom_range(1, 6))
                    send(ecf_pkg::OP_ADD, pick_vertex(), pick_vertex());
                send(ecf_pkg::OP_FINISH);
                read_tour(1);
            end else begin
                send(ecf_pkg::t_opcode'($urandom_range(3)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        #50ms;
        $display("eulerian_cycle_finder test failed");
        $finish;
    end

    initial begin
        sb = new();
        sb.reset_state();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
        set_vertex_count(9'd256);

        // Directed: empty graph, extremes, imbalance, bad vertex, stale tour
        send(ecf_pkg::OP_READ);
        send(ecf_pkg::OP_FINISH);
        send(ecf_pkg::OP_READ);
        send(ecf_pkg::OP_ADD, 8'd0, 8'd255);
        send(ecf_pkg::OP_ADD, 8'd255, 8'd0);
        send(ecf_pkg::OP_FINISH);
        read_tour(1);
        send(ecf_pkg::OP_ADD, 8'd3, 8'd4);
        send(ecf_pkg::OP_FINISH);
        send(ecf_pkg::OP_CLEAR);
        send(ecf_pkg::OP_ADD, 8'd1, 8'd2);
        send(ecf_pkg::OP_ADD, 8'd2, 8'd1);
        send(ecf_pkg::OP_ADD, 8'd1, 8'd1);
        send(ecf_pkg::OP_FINISH);
        send(ecf_pkg::OP_READ);
        send(ecf_pkg::OP_FINISH);
        send(ecf_pkg::OP_READ);
        send(ecf_pkg::OP_ADD, 8'd10, 8'd20);
        send(ecf_pkg::OP_ADD, 8'd20, 8'd10);
        send(ecf_pkg::OP_READ);
        // Hold off until every result is in, then shrink below held edges
        set_vertex_count(9'd5);
        send(ecf_pkg::OP_FINISH);
        send(ecf_pkg::OP_CLEAR);
        send(ecf_pkg::OP_ADD, 8'd9, 8'd1);
        send(ecf_pkg::OP_FINISH);
        send(ecf_pkg::OP_READ);
        set_vertex_count(9'd256);
        send(ecf_pkg::OP_CLEAR);

        gap_pct = 0;   random_phase(140);
        set_vertex_count(9'd8);
        gap_pct = 46;  random_phase(110);
        set_vertex_count(9'd1);
        gap_pct = 0;   random_phase(40);
        set_vertex_count(9'd0);
        gap_pct = 23;  random_phase(30);
        set_vertex_count(9'd511);
        gap_pct = 23;  random_phase(120);
        set_vertex_count(9'd37);
        gap_pct = 46;  random_phase(110);

        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("eulerian_cycle_finder test passed");
        end else begin
            $display("eulerian_cycle_finder test failed");
        end
        $finish;
    end
endmodule
